>>> sv/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU frame table package
// Sizes, sequencer states, table commands and status shared by the LRU
// page replacement block.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_WIDTH = 16;

  localparam int PAGE_IN_W = 16;
  localparam int SLOT_W    = 3;
  localparam int FAULT_W   = 32;
  localparam int CFG_W     = 4;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  localparam logic [CFG_W-1:0]   NUM_FRAMES_RESET = CFG_W'(8);
  localparam logic [FAULT_W-1:0] FAULT_MAX        = {FAULT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    UPD_HIT,
    UPD_FILL,
    UPD_EVICT
  } upd_e;

  typedef struct packed {
    logic                  clear;
    logic                  commit;
    upd_e                  kind;
    logic [IDX_W-1:0]      slot;
    logic [PAGE_WIDTH-1:0] page;
  } tbl_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_WIDTH-1:0] page;
    logic [RANK_W-1:0]     rank;
  } tbl_entry_t;

  typedef struct packed {
    tbl_entry_t         entry;
    logic [FAULT_W-1:0] fault_next;
  } tbl_stat_t;

  // A frame count of zero means one frame; counts above FRAMES mean FRAMES.
  function automatic logic [CNT_W-1:0] clamp_frames(logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] n;
    if (v == '0) begin
      n = CNT_W'(1);
    end else if (int'(v) > FRAMES) begin
      n = CNT_W'(FRAMES);
    end else begin
      n = CNT_W'(v);
    end
    return n;
  endfunction

endpackage

>>> sv/lru_req_if.sv
// ----------------------------------------------------------------------------
// LRU request channel
// Valid/ready channel that carries one page reference.
// ----------------------------------------------------------------------------
interface lru_req_if;
  logic                           valid;
  logic                           ready;
  logic [lru_pkg::PAGE_IN_W-1:0]  page;
  logic                           first_reference;
  logic                           last_reference;

  modport source (output valid, page, first_reference, last_reference, input ready);
  modport sink   (input valid, page, first_reference, last_reference, output ready);
endinterface

>>> sv/lru_rsp_if.sv
// ----------------------------------------------------------------------------
// LRU response channel
// Valid/ready channel that carries the outcome of one page reference.
// ----------------------------------------------------------------------------
interface lru_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [lru_pkg::SLOT_W-1:0]     slot;
  logic                           evicted_valid;
  logic [lru_pkg::PAGE_IN_W-1:0]  evicted_page;
  logic [lru_pkg::FAULT_W-1:0]    fault_total;
  logic                           run_end;

  modport source (output valid, hit, slot, evicted_valid, evicted_page, fault_total,
                  run_end, input ready);
  modport sink   (input valid, hit, slot, evicted_valid, evicted_page, fault_total,
                  run_end, output ready);
endinterface

>>> sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement frame table
// Fully associative table of page frames with least-recently-used
// replacement and a saturating fault counter.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_if carries one page reference. The block answers each
//   request with exactly one response on rsp_if: hit flag, frame slot, the
//   evicted page if a resident page was replaced, the running fault total
//   and an echo of last_reference. first_reference empties the table and
//   clears the fault count before the reference is handled.
//   cfg_we_i/cfg_wdata_i set the number of frames in use; write it only
//   while no request is in flight.
// Timing:
//   After a request is accepted, the frames in use pass through the single
//   compare unit one frame per cycle; the table is then updated and the
//   response registered once the response register is free. The next
//   request is taken only after that update, so requests do not overlap.
// Reset and stalls:
//   Reset empties every frame, clears the fault count and sets eight frames
//   in use. If the receiver stalls, the response register holds; a new
//   request may still be scanned but its update waits for the slot to free.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lru_pkg::CFG_W-1:0] cfg_wdata_i,
  lru_req_if.sink                   req_if,
  lru_rsp_if.source                 rsp_if
);

  logic [lru_pkg::CFG_W-1:0] num_frames_q;
  lru_pkg::tbl_cmd_t         cmd;
  lru_pkg::tbl_stat_t        stat;
  logic [lru_pkg::IDX_W-1:0] rd_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_frames_q <= lru_pkg::NUM_FRAMES_RESET;
    end else if (cfg_we_i) begin
      num_frames_q <= cfg_wdata_i;
    end
  end

  lru_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_frames_i (num_frames_q),
    .req          (req_if),
    .rsp          (rsp_if),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .rd_idx_o     (rd_idx)
  );

  lru_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .rd_idx_i (rd_idx),
    .stat_o   (stat)
  );

endmodule

>>> sv/lru_table.sv
// ----------------------------------------------------------------------------
// LRU frame table
// Holds page numbers, valid bits, recency ranks and the fault counter, and
// applies one hit, fill or eviction update or a clear per command.
// ----------------------------------------------------------------------------
module lru_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lru_pkg::tbl_cmd_t cmd_i,
  input  logic [lru_pkg::IDX_W-1:0] rd_idx_i,
  output lru_pkg::tbl_stat_t stat_o
);

  logic [lru_pkg::PAGE_WIDTH-1:0] page_q [lru_pkg::FRAMES];
  logic [lru_pkg::FRAMES-1:0]     valid_q, valid_d;
  logic [lru_pkg::RANK_W-1:0]     rank_q [lru_pkg::FRAMES];
  logic [lru_pkg::RANK_W-1:0]     rank_d [lru_pkg::FRAMES];
  logic [lru_pkg::FAULT_W-1:0]    fault_q, fault_d;
  logic [lru_pkg::RANK_W-1:0]     slot_rank;
  logic                           is_slot;

  assign slot_rank = rank_q[cmd_i.slot];

  always_comb begin
    fault_d = fault_q;
    if (cmd_i.clear) begin
      fault_d = '0;
    end else if (cmd_i.commit && (cmd_i.kind != lru_pkg::UPD_HIT) &&
                 (fault_q != lru_pkg::FAULT_MAX)) begin
      fault_d = fault_q + lru_pkg::FAULT_W'(1);
    end
  end

  // Each frame updates its own rank; only frames more recent than the
  // touched one age on a hit or an eviction, every valid frame ages on a fill.
  always_comb begin
    is_slot = 1'b0;
    valid_d = valid_q;
    for (int k = 0; k < lru_pkg::FRAMES; k++) begin
      rank_d[k] = rank_q[k];
      is_slot   = (lru_pkg::IDX_W'(k) == cmd_i.slot);
      if (cmd_i.clear) begin
        valid_d[k] = 1'b0;
        rank_d[k]  = '0;
      end else if (cmd_i.commit) begin
        case (cmd_i.kind)
          lru_pkg::UPD_HIT, lru_pkg::UPD_EVICT: begin
            if (is_slot) begin
              rank_d[k] = '0;
            end else if (valid_q[k] && (rank_q[k] < slot_rank)) begin
              rank_d[k] = rank_q[k] + lru_pkg::RANK_W'(1);
            end
          end
          lru_pkg::UPD_FILL: begin
            if (is_slot) begin
              rank_d[k]  = '0;
              valid_d[k] = 1'b1;
            end else if (valid_q[k]) begin
              rank_d[k] = rank_q[k] + lru_pkg::RANK_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
      for (int k = 0; k < lru_pkg::FRAMES; k++) begin
        rank_q[k] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      fault_q <= fault_d;
      for (int k = 0; k < lru_pkg::FRAMES; k++) begin
        rank_q[k] <= rank_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (cmd_i.kind != lru_pkg::UPD_HIT)) begin
      page_q[cmd_i.slot] <= cmd_i.page;
    end
  end

  assign stat_o.entry.valid = valid_q[rd_idx_i];
  assign stat_o.entry.page  = page_q[rd_idx_i];
  assign stat_o.entry.rank  = rank_q[rd_idx_i];
  assign stat_o.fault_next  = fault_d;

  a_no_clear_with_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.clear && cmd_i.commit))
    else $error("table clear and update in the same cycle");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (cmd_i.kind == lru_pkg::UPD_FILL)) |=> valid_q[$past(cmd_i.slot)])
    else $error("filled frame did not become valid");

  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clear |=> (fault_q >= $past(fault_q)))
    else $error("fault counter went down without a clear");

  a_touched_most_recent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (rank_q[$past(cmd_i.slot)] == '0))
    else $error("updated frame is not the most recent");

endmodule

>>> sv/lru_scan.sv
// ----------------------------------------------------------------------------
// LRU scan sequencer
// Walks the frames in use one per cycle through a single compare unit to
// find a hit, the first empty frame and the oldest frame, then issues the
// table update and registers the response.
// ----------------------------------------------------------------------------
module lru_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lru_pkg::CFG_W-1:0]  num_frames_i,
  lru_req_if.sink                    req,
  lru_rsp_if.source                  rsp,
  input  lru_pkg::tbl_stat_t         stat_i,
  output lru_pkg::tbl_cmd_t          cmd_o,
  output logic [lru_pkg::IDX_W-1:0]  rd_idx_o
);

  lru_pkg::state_e state_q, state_d;

  logic [lru_pkg::PAGE_WIDTH-1:0] page_q, page_d;
  logic                           last_q, last_d;
  logic [lru_pkg::CNT_W-1:0]      n_q, n_d;
  logic [lru_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic                           hit_q, hit_d;
  logic [lru_pkg::IDX_W-1:0]      hit_slot_q, hit_slot_d;
  logic                           empty_q, empty_d;
  logic [lru_pkg::IDX_W-1:0]      empty_slot_q, empty_slot_d;
  logic [lru_pkg::RANK_W-1:0]     best_q, best_d;
  logic [lru_pkg::IDX_W-1:0]      victim_q, victim_d;

  logic                           out_valid_q, out_valid_d;
  logic                           out_load;
  logic                           o_hit_q, o_hit_d;
  logic [lru_pkg::SLOT_W-1:0]     o_slot_q, o_slot_d;
  logic                           o_ev_q, o_ev_d;
  logic [lru_pkg::PAGE_IN_W-1:0]  o_ev_page_q, o_ev_page_d;
  logic [lru_pkg::FAULT_W-1:0]    o_fault_q, o_fault_d;
  logic                           o_end_q, o_end_d;

  logic                           scan_last;
  logic [lru_pkg::IDX_W-1:0]      upd_slot;

  assign scan_last = (lru_pkg::CNT_W'(idx_q) == (n_q - lru_pkg::CNT_W'(1)));

  always_comb begin
    state_d      = state_q;
    page_d       = page_q;
    last_d       = last_q;
    n_d          = n_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    hit_slot_d   = hit_slot_q;
    empty_d      = empty_q;
    empty_slot_d = empty_slot_q;
    best_d       = best_q;
    victim_d     = victim_q;
    out_load     = 1'b0;
    upd_slot     = hit_q ? hit_slot_q : (empty_q ? empty_slot_q : victim_q);
    rd_idx_o     = idx_q;

    cmd_o        = '0;
    cmd_o.kind   = hit_q ? lru_pkg::UPD_HIT : (empty_q ? lru_pkg::UPD_FILL : lru_pkg::UPD_EVICT);
    cmd_o.slot   = upd_slot;
    cmd_o.page   = page_q;

    case (state_q)
      lru_pkg::ST_IDLE: begin
        if (req.valid) begin
          page_d     = lru_pkg::PAGE_WIDTH'(req.page);
          last_d     = req.last_reference;
          n_d        = lru_pkg::clamp_frames(num_frames_i);
          idx_d      = '0;
          hit_d      = 1'b0;
          empty_d    = 1'b0;
          best_d     = '0;
          victim_d   = '0;
          cmd_o.clear = req.first_reference;
          state_d    = lru_pkg::ST_SCAN;
        end
      end
      lru_pkg::ST_SCAN: begin
        // The lowest matching frame wins, as does the lowest empty frame.
        if (!hit_q && stat_i.entry.valid && (stat_i.entry.page == page_q)) begin
          hit_d      = 1'b1;
          hit_slot_d = idx_q;
        end
        if (!empty_q && !stat_i.entry.valid) begin
          empty_d      = 1'b1;
          empty_slot_d = idx_q;
        end
        if (stat_i.entry.rank > best_q) begin
          best_d   = stat_i.entry.rank;
          victim_d = idx_q;
        end
        if (scan_last) begin
          state_d = lru_pkg::ST_UPDATE;
        end else begin
          idx_d = idx_q + lru_pkg::IDX_W'(1);
        end
      end
      lru_pkg::ST_UPDATE: begin
        // The victim is read here so its old page can be reported.
        rd_idx_o = victim_q;
        if (!out_valid_q || rsp.ready) begin
          cmd_o.commit = 1'b1;
          out_load     = 1'b1;
          state_d      = lru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lru_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    o_hit_d     = o_hit_q;
    o_slot_d    = o_slot_q;
    o_ev_d      = o_ev_q;
    o_ev_page_d = o_ev_page_q;
    o_fault_d   = o_fault_q;
    o_end_d     = o_end_q;
    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      o_hit_d     = hit_q;
      o_slot_d    = lru_pkg::SLOT_W'(upd_slot);
      o_ev_d      = !hit_q && !empty_q;
      o_ev_page_d = (!hit_q && !empty_q) ? lru_pkg::PAGE_IN_W'(stat_i.entry.page) : '0;
      o_fault_d   = stat_i.fault_next;
      o_end_d     = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lru_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      empty_q     <= 1'b0;
      best_q      <= '0;
      victim_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      empty_q     <= empty_d;
      best_q      <= best_d;
      victim_q    <= victim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    last_q       <= last_d;
    n_q          <= n_d;
    hit_slot_q   <= hit_slot_d;
    empty_slot_q <= empty_slot_d;
    o_hit_q      <= o_hit_d;
    o_slot_q     <= o_slot_d;
    o_ev_q       <= o_ev_d;
    o_ev_page_q  <= o_ev_page_d;
    o_fault_q    <= o_fault_d;
    o_end_q      <= o_end_d;
  end

  assign req.ready         = (state_q == lru_pkg::ST_IDLE);
  assign rsp.valid         = out_valid_q;
  assign rsp.hit           = o_hit_q;
  assign rsp.slot          = o_slot_q;
  assign rsp.evicted_valid = o_ev_q;
  assign rsp.evicted_page  = o_ev_page_q;
  assign rsp.fault_total   = o_fault_q;
  assign rsp.run_end       = o_end_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lru_pkg::ST_SCAN) |-> (lru_pkg::CNT_W'(idx_q) < n_q))
    else $error("scan index beyond the frames in use");

  a_update_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lru_pkg::ST_UPDATE) && (!out_valid_q || rsp.ready)) |=> out_valid_q)
    else $error("finished update did not present a response");

  a_update_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == lru_pkg::ST_UPDATE) && out_valid_q && !rsp.ready) |->
      !cmd_o.commit)
    else $error("table updated while the previous response is stalled");

endmodule

>>> bench/lru_page_replacement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page references through the request channel under random idling on
// both sides and checks each response against a cycle-free model of the
// frame table kept in the bench. The frame count is changed between
// reference strings and within them, only when nothing is in flight.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;

  typedef struct packed {
    logic                          hit;
    logic [lru_pkg::SLOT_W-1:0]    slot;
    logic                          evicted_valid;
    logic [lru_pkg::PAGE_IN_W-1:0] evicted_page;
    logic [lru_pkg::FAULT_W-1:0]   fault_total;
    logic                          run_end;
  } outcome_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [lru_pkg::CFG_W-1:0] cfg_wdata_i;

  lru_req_if req_ch ();
  lru_rsp_if rsp_ch ();

  lru_page_replacement DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_if      (req_ch),
    .rsp_if      (rsp_ch)
  );

  // Bench copy of the frame table.
  logic [lru_pkg::PAGE_IN_W-1:0] tbl_page [lru_pkg::FRAMES];
  bit                            tbl_used [lru_pkg::FRAMES];
  int                            tbl_age  [lru_pkg::FRAMES];
  logic [lru_pkg::FAULT_W-1:0]   fault_tally;
  logic [lru_pkg::CFG_W-1:0]     frames_cfg;

  outcome_t pending_outcomes [$];
  int       err_count     = 0;
  int       send_idle_pct = 22;
  int       recv_idle_pct = 45;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_table();
    for (int j = 0; j < lru_pkg::FRAMES; j++) begin
      tbl_page[j] = '0;
      tbl_used[j] = 1'b0;
      tbl_age[j]  = 0;
    end
    fault_tally = '0;
  endfunction

  // Frame s becomes the most recent; frames more recent than it age by one.
  function automatic void promote_frame(int s);
    int old_age;
    old_age = tbl_age[s];
    for (int j = 0; j < lru_pkg::FRAMES; j++) begin
      if (tbl_used[j] && j != s && tbl_age[j] < old_age) tbl_age[j]++;
    end
    tbl_age[s] = 0;
  endfunction

  function automatic outcome_t resolve_reference(logic [lru_pkg::PAGE_IN_W-1:0] page,
                                                 bit first_ref, bit last_ref);
    outcome_t o;
    int       n;
    int       s;
    int       best;
    bit       found_hit;
    bit       found_empty;
    o           = '0;
    s           = 0;
    found_hit   = 1'b0;
    found_empty = 1'b0;
    if (first_ref) clear_table();
    if (frames_cfg == '0) n = 1;
    else if (int'(frames_cfg) > lru_pkg::FRAMES) n = lru_pkg::FRAMES;
    else n = int'(frames_cfg);

    for (int j = 0; j < n; j++) begin
      if (!found_hit && tbl_used[j] && tbl_page[j] == page) begin
        found_hit = 1'b1;
        s         = j;
      end
    end

    if (found_hit) begin
      promote_frame(s);
    end else begin
      for (int j = 0; j < n; j++) begin
        if (!found_empty && !tbl_used[j]) begin
          found_empty = 1'b1;
          s           = j;
        end
      end
      if (found_empty) begin
        // A fresh entry pushes every resident frame one step older.
        for (int k = 0; k < lru_pkg::FRAMES; k++) begin
          if (tbl_used[k]) tbl_age[k]++;
        end
        tbl_used[s] = 1'b1;
        tbl_page[s] = page;
        tbl_age[s]  = 0;
      end else begin
        best = 0;
        s    = 0;
        for (int j = 0; j < n; j++) begin
          if (tbl_age[j] > best) begin
            best = tbl_age[j];
            s    = j;
          end
        end
        o.evicted_valid = 1'b1;
        o.evicted_page  = tbl_page[s];
        tbl_page[s]     = page;
        promote_frame(s);
      end
      if (fault_tally != lru_pkg::FAULT_MAX) fault_tally++;
    end

    o.hit         = found_hit;
    o.slot        = lru_pkg::SLOT_W'(s);
    o.fault_total = fault_tally;
    o.run_end     = last_ref;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= 10) begin
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    end
  endfunction

  // Receiver: random back-pressure on the response channel.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("response with no request outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        check_field("hit", 32'(want.hit), 32'(rsp_ch.hit));
        check_field("slot", 32'(want.slot), 32'(rsp_ch.slot));
        check_field("evicted_valid", 32'(want.evicted_valid), 32'(rsp_ch.evicted_valid));
        check_field("evicted_page", 32'(want.evicted_page), 32'(rsp_ch.evicted_page));
        check_field("fault_total", want.fault_total, rsp_ch.fault_total);
        check_field("run_end", 32'(want.run_end), 32'(rsp_ch.run_end));
      end
    end
  end

  // Valid is left high after acceptance so back-to-back requests need no
  // drop; it only falls when the sender idles or the bench drains.
  task automatic send_reference(logic [lru_pkg::PAGE_IN_W-1:0] page, bit first_ref,
                                bit last_ref);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.page            <= page;
    req_ch.first_reference <= first_ref;
    req_ch.last_reference  <= last_ref;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    pending_outcomes.push_back(resolve_reference(page, first_ref, last_ref));
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_frame_count(logic [lru_pkg::CFG_W-1:0] v);
    drain();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    frames_cfg  = v;
  endtask

  // Fill all eight frames, hit, evict the oldest, and restart a string.
  task automatic test_directed_basics();
    send_reference(16'h0000, 1'b1, 1'b0);
    send_reference(16'hFFFF, 1'b0, 1'b0);
    send_reference(16'h0000, 1'b0, 1'b0);
    send_reference(16'h5555, 1'b0, 1'b0);
    send_reference(16'hAAAA, 1'b0, 1'b0);
    send_reference(16'h0001, 1'b0, 1'b0);
    send_reference(16'h8000, 1'b0, 1'b0);
    send_reference(16'h1234, 1'b0, 1'b0);
    send_reference(16'h00FF, 1'b0, 1'b0);
    send_reference(16'hFEDC, 1'b0, 1'b0);
    send_reference(16'h0000, 1'b0, 1'b1);
    send_reference(16'hFFFF, 1'b1, 1'b1);
  endtask

  // Counts out of range, shrinking and growing with residents left behind.
  task automatic test_frame_counts();
    set_frame_count(4'd15);
    send_reference(16'h0010, 1'b1, 1'b0);
    send_reference(16'h0011, 1'b0, 1'b0);
    send_reference(16'h0012, 1'b0, 1'b0);
    send_reference(16'h0013, 1'b0, 1'b0);
    set_frame_count(4'd2);
    send_reference(16'h0013, 1'b0, 1'b0);
    send_reference(16'h0013, 1'b0, 1'b0);
    // Page 0x13 now sits in two frames; the lower one must win.
    set_frame_count(4'd9);
    send_reference(16'h0013, 1'b0, 1'b0);
    send_reference(16'h0012, 1'b0, 1'b0);
    set_frame_count(4'd1);
    send_reference(16'h0007, 1'b0, 1'b0);
    set_frame_count(4'd0);
    send_reference(16'h0008, 1'b0, 1'b1);
  endtask

  // Mostly reference strings over a small page pool so hits and evictions
  // are frequent; some strings carry on without a clear, some are noise.
  task automatic test_reference_strings(int items, int send_pct, int recv_pct);
    logic [lru_pkg::PAGE_IN_W-1:0] pool [12];
    int                            sent;
    int                            len;
    int                            pool_n;
    bit                            noise;
    bit                            fresh;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent          = 0;
    while (sent < items) begin
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(9) < 7) begin
          set_frame_count(lru_pkg::CFG_W'($urandom_range(1, lru_pkg::FRAMES)));
        end else begin
          set_frame_count(lru_pkg::CFG_W'($urandom_range(15)));
        end
      end
      noise  = ($urandom_range(99) < 15);
      fresh  = ($urandom_range(4) != 0);
      len    = noise ? $urandom_range(1, 10) : $urandom_range(4, 40);
      pool_n = $urandom_range(1, 12);
      for (int k = 0; k < 12; k++) pool[k] = lru_pkg::PAGE_IN_W'($urandom);
      for (int i = 0; i < len; i++) begin
        if (noise) begin
          send_reference(lru_pkg::PAGE_IN_W'($urandom), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end else if ($urandom_range(9) == 0) begin
          send_reference(lru_pkg::PAGE_IN_W'($urandom), fresh && i == 0, i == len - 1);
        end else begin
          send_reference(pool[$urandom_range(pool_n - 1)], fresh && i == 0, i == len - 1);
        end
      end
      sent += len;
    end
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_wdata_i            <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.page            <= '0;
    req_ch.first_reference <= 1'b0;
    req_ch.last_reference  <= 1'b0;
    clear_table();
    frames_cfg = lru_pkg::NUM_FRAMES_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_frame_counts();
    test_reference_strings(550, 22, 45);
    test_reference_strings(550, 45, 22);
    test_reference_strings(550, 0, 0);
    drain();

    if (err_count == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lru_pkg.sv
sv/lru_req_if.sv
sv/lru_rsp_if.sv
sv/lru_table.sv
sv/lru_scan.sv
sv/lru_page_replacement.sv
bench/lru_page_replacement_tb.sv
